// ----- rtl/cpu_job_scheduler_tick_macros.svh -----
// Assertion helpers for the scheduler block. Both sample on aclk and are
// switched off while aresetn is low.
`ifndef CPU_JOB_SCHEDULER_TICK_MACROS_SVH
`define CPU_JOB_SCHEDULER_TICK_MACROS_SVH

// Same-cycle implication.
`define CJST_ASSERT_HOLD(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CJST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/cjst_pkg.sv -----
`default_nettype none

package cjst_pkg;

    // Request actions
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_POLICY     = 2'd0;
    localparam logic [1:0] REG_QUANTUM    = 2'd1;
    localparam logic [1:0] REG_USED_SLOTS = 2'd2;

    // Policy codes
    localparam logic [1:0] POL_FIFO = 2'd0;
    localparam logic [1:0] POL_RR   = 2'd1;
    localparam logic [1:0] POL_SJF  = 2'd2;
    localparam logic [1:0] POL_PSJF = 2'd3;

    localparam logic [15:0] QUANTUM_RESET = 16'd500;
    localparam logic [4:0]  USED_RESET    = 5'd16;
    localparam logic [4:0]  RETIRED_MAX   = 5'd31;

    typedef struct packed {
        logic        action;
        logic [3:0]  slot;
        logic [31:0] ready_time;
        logic [23:0] run_length;
    } in_t;

    typedef struct packed {
        logic [31:0] time_now;
        logic [3:0]  run_slot;
        logic        cpu_busy;
        logic        switched;
        logic        completed;
        logic [3:0]  completed_slot;
        logic [15:0] arrived_mask;
        logic        all_done;
    } out_t;

endpackage

`default_nettype wire

// ----- rtl/cjst_ram.sv -----
`default_nettype none

module cjst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire                       clk,
    input  wire                       we,
    input  wire [$clog2(DEPTH)-1:0]   waddr,
    input  wire [WIDTH-1:0]           wdata,
    input  wire [$clog2(DEPTH)-1:0]   raddr,
    output logic [WIDTH-1:0]          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/cpu_job_scheduler_tick.sv -----
// Single-processor job scheduler, at most one time tick per tick request.
// Input channel (s_valid/s_ready/s_data): a load request writes one job slot
// (ready time, run length), clears its arrived mark and returns nothing. A tick
// request advances time by one tick (not when it retires the last job or all
// jobs are done) and returns exactly one result (m_valid/m_ready/m_data).
// Config: APB-style port, policy 0x0, quantum 0x4, used_slots 0x8. The user
// writes it only while idle; the block does not enforce it. pready is tied high.
// A tick walks the slots in use through one shared compare unit reading the
// slot memories one entry per cycle, after S_MOD has found the rotation start
// by repeatedly subtracting amount from last+1, last being the most recently
// dispatched slot. A tick that retires the last job goes from S_RET straight
// to S_OUT; ticks after all jobs are done go from S_IDLE straight to S_OUT.
// The result sits in an output register; s_ready returns while it waits,
// and the next tick stalls only when it wants to write a new result.
// Reset clears the time counter, the running job and the arrived marks, and
// sets the config registers to their defaults. Slot memories are not cleared:
// every slot in use must be loaded before the first tick.
`default_nettype none

module cpu_job_scheduler_tick
    import cjst_pkg::*;
#(
    parameter int SLOTS     = 16,
    parameter int TIME_BITS = 32
) (
    input  wire         aclk,
    input  wire         aresetn,
    // request channel
    input  wire         s_valid,
    output logic        s_ready,
    input  wire in_t    s_data,
    // result channel
    output logic        m_valid,
    input  wire         m_ready,
    output out_t        m_data,
    // config port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

`include "cpu_job_scheduler_tick_macros.svh"

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;  // wait for request
    localparam logic [2:0] S_RET  = 3'd1;  // retire check on running job
    localparam logic [2:0] S_MOD  = 3'd2;  // rotation start for round robin
    localparam logic [2:0] S_SCAN = 3'd3;  // walk slots: arrivals + pick
    localparam logic [2:0] S_PICK = 3'd4;  // last scanned slot
    localparam logic [2:0] S_DISP = 3'd5;  // dispatch, read chosen slot
    localparam logic [2:0] S_DEC  = 3'd6;  // decrement, build result
    localparam logic [2:0] S_OUT  = 3'd7;  // hand result to output register

    logic [2:0]           state_reg, state_next;
    logic [1:0]           policy_reg, policy_next;
    logic [15:0]          quantum_reg, quantum_next;
    logic [4:0]           used_reg, used_next;

    logic [TIME_BITS-1:0] tick_reg, tick_next;
    logic [SLOT_W-1:0]    cur_job_reg, cur_job_next;
    logic                 cur_valid_reg, cur_valid_next;
    logic [4:0]           retired_reg, retired_next;
    logic [15:0]          slice_reg, slice_next;
    logic                 done_reg, done_next;
    logic [SLOTS-1:0]     arrived_reg, arrived_next;

    logic                 keep_reg, keep_next;
    logic [CNT_W-1:0]     rot_reg, rot_next;
    logic [SLOT_W-1:0]    issue_reg, issue_next;
    logic                 chk_valid_reg, chk_valid_next;
    logic [SLOT_W-1:0]    chk_idx_reg, chk_idx_next;
    logic                 best_valid_reg, best_valid_next;
    logic [SLOT_W-1:0]    best_idx_reg, best_idx_next;
    logic [31:0]          best_key_reg, best_key_next;
    logic                 any_valid_reg, any_valid_next;
    logic [SLOT_W-1:0]    any_idx_reg, any_idx_next;
    logic                 hi_valid_reg, hi_valid_next;
    logic [SLOT_W-1:0]    hi_idx_reg, hi_idx_next;
    logic [15:0]          mask_reg, mask_next;

    out_t                 res_reg, res_next;
    logic                 m_valid_reg, m_valid_next;
    out_t                 m_data_reg, m_data_next;

    // memory ports
    logic                 rt_we;
    logic                 rem_we;
    logic [SLOT_W-1:0]    waddr;
    logic [23:0]          rem_wdata;
    logic [SLOT_W-1:0]    raddr;
    logic [31:0]          rt_rdata;
    logic [23:0]          rem_rdata;

    // helpers
    logic [CNT_W-1:0]     amount;
    logic [15:0]          q_eff;
    logic                 s_fire;
    logic                 cfg_wr;
    logic [SLOT_W+3:0]    slot_ext;
    logic [SLOT_W-1:0]    slot_idx;
    logic                 slot_ok;
    logic [SLOT_W+3:0]    cur_ext;
    logic [SLOT_W+3:0]    chk_ext;
    logic                 match;
    logic                 elig;
    logic [31:0]          key;
    logic [4:0]           retired_inc;
    logic [16:0]          slice_inc;
    logic                 pick_valid;
    logic [SLOT_W-1:0]    pick_idx;

    cjst_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_ready_ram (
        .clk   (aclk),
        .we    (rt_we),
        .waddr (waddr),
        .wdata (s_data.ready_time),
        .raddr (raddr),
        .rdata (rt_rdata)
    );

    cjst_ram #(.WIDTH(24), .DEPTH(SLOTS)) u_remain_ram (
        .clk   (aclk),
        .we    (rem_we),
        .waddr (waddr),
        .wdata (rem_wdata),
        .raddr (raddr),
        .rdata (rem_rdata)
    );

    assign s_ready = (state_reg == S_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;

    // effective register values
    always_comb begin
        if (used_reg == 5'd0) begin
            amount = CNT_W'(1);
        end else if (32'(used_reg) > SLOTS) begin
            amount = CNT_W'(SLOTS);
        end else begin
            amount = CNT_W'(used_reg);
        end
    end
    assign q_eff = (quantum_reg == 16'd0) ? 16'd1 : quantum_reg;

    assign slot_ext = {{SLOT_W{1'b0}}, s_data.slot};
    assign slot_idx = slot_ext[SLOT_W-1:0];
    assign slot_ok  = 32'(s_data.slot) < SLOTS;
    assign cur_ext  = {4'b0, cur_job_reg};
    assign chk_ext  = {4'b0, chk_idx_reg};

    // per-slot compare unit, fed by the memory read of the previous cycle
    assign match = {{TIME_BITS{1'b0}}, rt_rdata} == {32'b0, tick_reg};
    assign elig  = (arrived_reg[chk_idx_reg] || match) && (rem_rdata != 24'd0);
    assign key   = (policy_reg == POL_FIFO) ? rt_rdata : {8'b0, rem_rdata};

    assign retired_inc = (retired_reg == RETIRED_MAX) ? RETIRED_MAX
                                                      : retired_reg + 5'd1;
    assign slice_inc   = {1'b0, slice_reg} + 17'd1;

    // final choice after the scan
    always_comb begin
        pick_valid = 1'b0;
        pick_idx   = cur_job_reg;
        if (keep_reg) begin
            pick_valid = 1'b1;
        end else if (policy_reg == POL_RR) begin
            if (cur_valid_reg && hi_valid_reg) begin
                pick_valid = 1'b1;
                pick_idx   = hi_idx_reg;
            end else begin
                pick_valid = any_valid_reg;
                pick_idx   = any_idx_reg;
            end
        end else begin
            pick_valid = best_valid_reg;
            pick_idx   = best_idx_reg;
        end
    end

    // config read
    always_comb begin
        unique case (paddr[3:2])
            REG_POLICY:     prdata = {30'b0, policy_reg};
            REG_QUANTUM:    prdata = {16'b0, quantum_reg};
            REG_USED_SLOTS: prdata = {27'b0, used_reg};
            default:        prdata = 32'b0;
        endcase
    end

    // sequencer
    always_comb begin
        state_next      = state_reg;
        policy_next     = policy_reg;
        quantum_next    = quantum_reg;
        used_next       = used_reg;
        tick_next       = tick_reg;
        cur_job_next    = cur_job_reg;
        cur_valid_next  = cur_valid_reg;
        retired_next    = retired_reg;
        slice_next      = slice_reg;
        done_next       = done_reg;
        arrived_next    = arrived_reg;
        keep_next       = keep_reg;
        rot_next        = rot_reg;
        issue_next      = issue_reg;
        chk_valid_next  = 1'b0;
        chk_idx_next    = chk_idx_reg;
        best_valid_next = best_valid_reg;
        best_idx_next   = best_idx_reg;
        best_key_next   = best_key_reg;
        any_valid_next  = any_valid_reg;
        any_idx_next    = any_idx_reg;
        hi_valid_next   = hi_valid_reg;
        hi_idx_next     = hi_idx_reg;
        mask_next       = mask_reg;
        res_next        = res_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;

        rt_we     = 1'b0;
        rem_we    = 1'b0;
        waddr     = slot_idx;
        rem_wdata = s_data.run_length;
        raddr     = cur_job_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_POLICY:     policy_next  = pwdata[1:0];
                REG_QUANTUM:    quantum_next = pwdata[15:0];
                REG_USED_SLOTS: used_next    = pwdata[4:0];
                default:        ;
            endcase
        end

        // scanned slot from the previous read
        if (chk_valid_reg) begin
            if (match) begin
                arrived_next[chk_idx_reg] = 1'b1;
                if (32'(chk_idx_reg) < 16) begin
                    mask_next[chk_ext[3:0]] = 1'b1;
                end
            end
            if (elig) begin
                if (!any_valid_reg) begin
                    any_valid_next = 1'b1;
                    any_idx_next   = chk_idx_reg;
                end
                if (!hi_valid_reg && CNT_W'(chk_idx_reg) >= rot_reg) begin
                    hi_valid_next = 1'b1;
                    hi_idx_next   = chk_idx_reg;
                end
                if (!best_valid_reg || key < best_key_reg) begin
                    best_valid_next = 1'b1;
                    best_idx_next   = chk_idx_reg;
                    best_key_next   = key;
                end
            end
        end

        unique case (state_reg)
            S_IDLE: begin
                // raddr holds the running job, so its remaining time is
                // ready in S_RET
                if (s_fire) begin
                    if (s_data.action == ACT_LOAD) begin
                        if (slot_ok) begin
                            rt_we  = 1'b1;
                            rem_we = 1'b1;
                            arrived_next[slot_idx] = 1'b0;
                        end
                    end else begin
                        res_next          = '0;
                        res_next.time_now = 32'(tick_reg);
                        if (done_reg) begin
                            res_next.all_done = 1'b1;
                            state_next        = S_OUT;
                        end else begin
                            state_next = S_RET;
                        end
                    end
                end
            end

            S_RET: begin
                mask_next       = 16'b0;
                best_valid_next = 1'b0;
                any_valid_next  = 1'b0;
                hi_valid_next   = 1'b0;
                issue_next      = '0;
                rot_next        = CNT_W'(cur_job_reg) + CNT_W'(1);
                keep_next       = cur_valid_reg &&
                                  ((policy_reg == POL_FIFO) || (policy_reg == POL_SJF) ||
                                   ((policy_reg == POL_RR) && (slice_reg != 16'd0)));
                state_next      = S_MOD;
                if (cur_valid_reg && rem_rdata == 24'd0) begin
                    cur_valid_next          = 1'b0;
                    keep_next               = 1'b0;
                    retired_next            = retired_inc;
                    res_next.completed      = 1'b1;
                    res_next.completed_slot = cur_ext[3:0];
                    if (32'(retired_inc) >= 32'(amount)) begin
                        done_next         = 1'b1;
                        res_next.all_done = 1'b1;
                        state_next        = S_OUT;
                    end
                end
            end

            S_MOD: begin
                // rotation start = (current + 1) mod amount, one subtract a cycle
                if (rot_reg >= amount) begin
                    rot_next = rot_reg - amount;
                end else begin
                    state_next = S_SCAN;
                end
            end

            S_SCAN: begin
                raddr          = issue_reg;
                chk_valid_next = 1'b1;
                chk_idx_next   = issue_reg;
                if (CNT_W'(issue_reg) + CNT_W'(1) == amount) begin
                    state_next = S_PICK;
                end else begin
                    issue_next = issue_reg + SLOT_W'(1);
                end
            end

            S_PICK: begin
                state_next = S_DISP;
            end

            S_DISP: begin
                if (pick_valid && (!cur_valid_reg || pick_idx != cur_job_reg)) begin
                    cur_job_next      = pick_idx;
                    cur_valid_next    = 1'b1;
                    slice_next        = 16'd0;
                    res_next.switched = 1'b1;
                end
                raddr      = cur_job_next;
                state_next = S_DEC;
            end

            S_DEC: begin
                if (cur_valid_reg) begin
                    waddr             = cur_job_reg;
                    rem_wdata         = rem_rdata - 24'd1;
                    rem_we            = (rem_rdata != 24'd0);
                    res_next.run_slot = cur_ext[3:0];
                    res_next.cpu_busy = 1'b1;
                end
                res_next.arrived_mask = mask_reg;
                if (slice_inc >= {1'b0, q_eff}) begin
                    slice_next = 16'd0;
                end else begin
                    slice_next = slice_inc[15:0];
                end
                if (tick_reg != {TIME_BITS{1'b1}}) begin
                    tick_next = tick_reg + TIME_BITS'(1);
                end
                state_next = S_OUT;
            end

            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            policy_reg    <= POL_FIFO;
            quantum_reg   <= QUANTUM_RESET;
            used_reg      <= USED_RESET;
            tick_reg      <= '0;
            cur_job_reg   <= '0;
            cur_valid_reg <= 1'b0;
            retired_reg   <= 5'd0;
            slice_reg     <= 16'd0;
            done_reg      <= 1'b0;
            arrived_reg   <= '0;
            chk_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            policy_reg    <= policy_next;
            quantum_reg   <= quantum_next;
            used_reg      <= used_next;
            tick_reg      <= tick_next;
            cur_job_reg   <= cur_job_next;
            cur_valid_reg <= cur_valid_next;
            retired_reg   <= retired_next;
            slice_reg     <= slice_next;
            done_reg      <= done_next;
            arrived_reg   <= arrived_next;
            chk_valid_reg <= chk_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // datapath, no reset needed
    always_ff @(posedge aclk) begin
        keep_reg       <= keep_next;
        rot_reg        <= rot_next;
        issue_reg      <= issue_next;
        chk_idx_reg    <= chk_idx_next;
        best_valid_reg <= best_valid_next;
        best_idx_reg   <= best_idx_next;
        best_key_reg   <= best_key_next;
        any_valid_reg  <= any_valid_next;
        any_idx_reg    <= any_idx_next;
        hi_valid_reg   <= hi_valid_next;
        hi_idx_reg     <= hi_idx_next;
        mask_reg       <= mask_next;
        res_reg        <= res_next;
        m_data_reg     <= m_data_next;
    end

    // checks
    `CJST_ASSERT_NEXT(a_done_sticky, done_reg, done_reg, "done flag dropped without reset")
    `CJST_ASSERT_NEXT(a_retired_mono, 1'b1, retired_reg >= $past(retired_reg),
                      "retired count went down")
    `CJST_ASSERT_HOLD(a_busy_not_done, m_valid_reg && m_data_reg.cpu_busy,
                      !m_data_reg.all_done, "busy result flagged as done")
    `CJST_ASSERT_HOLD(a_scan_bound, state_reg == S_SCAN, CNT_W'(issue_reg) < amount,
                      "scan index beyond slots in use")

endmodule

`default_nettype wire
